### hw/rtl/wsd_pkg.sv
// Package for the WebSocket frame deframer: transfer payload structs,
// status codes and length constants. No dependencies.
`default_nettype none

package wsd_pkg;

  localparam int LENGTH_WIDTH_DEF = 64;

  // Seven-bit length codes from the second header byte
  localparam logic [6:0] LEN_MAX7  = 7'd125;
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  typedef enum logic [1:0] {
    ST_DATA       = 2'd0,
    ST_EMPTY      = 2'd1,
    ST_INCOMPLETE = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       chunk_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_last;
    logic       fin_bit;
    logic [3:0] frame_opcode;
    status_t    status;
  } out_item_t;

endpackage

`default_nettype wire

### hw/rtl/wsd_in_reg.sv
// Input register stage of the deframer: holds one accepted byte transfer.
// Depends on wsd_pkg.
`default_nettype none

module wsd_in_reg
  import wsd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  input  wire logic     advance,
  output logic          item_valid,
  output in_item_t      item
);

  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      item <= in_data;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/wsd_parser.sv
// Frame header parser and payload unmasker: parse state and the single-pass
// next-state / result logic for one byte. Depends on wsd_pkg.
`default_nettype none

module wsd_parser
  import wsd_pkg::*;
#(
  parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     item_valid,
  input  wire logic     advance,
  input  wire in_item_t item,
  output logic          result_valid,
  output out_item_t     result
);

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_DATA = 3'd4
  } phase_t;

  localparam logic [LENGTH_WIDTH-1:0] LEN_ALL = {LENGTH_WIDTH{1'b1}};

  phase_t                  phase, phase_next;
  logic [2:0]              cnt, cnt_next;
  logic [LENGTH_WIDTH-1:0] remaining, remaining_next;
  logic [31:0]             key, key_next;
  logic [1:0]              pos, pos_next;
  logic                    masked, masked_next;
  logic                    fin, fin_next;
  logic [3:0]              opcode, opcode_next;

  logic                    fire;
  logic [7:0]              b;
  logic [7:0]              kb;
  logic [LENGTH_WIDTH-1:0] rem_dec;
  logic                    hdr_end;   // header finished on this byte
  logic                    rem_zero;

  assign fire = item_valid && advance;
  assign b    = item.in_byte;

  always_comb begin
    case (pos)
      2'd0:    kb = key[31:24];
      2'd1:    kb = key[23:16];
      2'd2:    kb = key[15:8];
      default: kb = key[7:0];
    endcase
    if (!masked) begin
      kb = 8'd0;
    end
  end

  assign rem_dec  = remaining - LENGTH_WIDTH'(1);
  assign rem_zero = (remaining_next == '0);

  always_comb begin
    phase_next     = phase;
    cnt_next       = cnt;
    remaining_next = remaining;
    key_next       = key;
    pos_next       = pos;
    masked_next    = masked;
    fin_next       = fin;
    opcode_next    = opcode;
    hdr_end        = 1'b0;
    result_valid   = 1'b0;
    result         = '0;

    case (phase)
      PH_HDR1: begin
        masked_next = b[7];
        if (b[6:0] <= LEN_MAX7) begin
          remaining_next = LENGTH_WIDTH'(b[6:0]);
          hdr_end        = 1'b1;
        end else begin
          remaining_next = '0;
          phase_next     = PH_EXT;
          cnt_next       = (b[6:0] == LEN_EXT16) ? 3'd1 : 3'd7;
        end
      end
      PH_EXT: begin
        // saturate once a further shift would overflow the length register
        if (|remaining[LENGTH_WIDTH-1 -: 8]) begin
          remaining_next = LEN_ALL;
        end else begin
          remaining_next = {remaining[LENGTH_WIDTH-9:0], b};
        end
        if (cnt == 3'd0) begin
          hdr_end = 1'b1;
        end else begin
          cnt_next = cnt - 3'd1;
        end
      end
      PH_KEY: begin
        key_next = {key[23:0], b};
        if (cnt == 3'd0) begin
          hdr_end = 1'b1;
        end else begin
          cnt_next = cnt - 3'd1;
        end
      end
      PH_DATA: begin
        pos_next              = pos + 2'd1;
        remaining_next        = rem_dec;
        result_valid          = 1'b1;
        result.out_byte       = b ^ kb;
        result.status         = ST_DATA;
        if (rem_dec == '0) begin
          phase_next        = PH_HDR0;
          result.frame_last = 1'b1;
        end
      end
      default: begin
        fin_next       = b[7];
        opcode_next    = b[3:0];
        masked_next    = 1'b0;
        remaining_next = '0;
        pos_next       = 2'd0;
        cnt_next       = 3'd0;
        phase_next     = PH_HDR1;
      end
    endcase

    // Length known: key bytes follow, or the header is done
    if (hdr_end) begin
      if (phase != PH_KEY && masked_next) begin
        phase_next = PH_KEY;
        cnt_next   = 3'd3;
      end else begin
        pos_next = 2'd0;
        cnt_next = 3'd0;
        if (rem_zero) begin
          phase_next        = PH_HDR0;
          result_valid      = 1'b1;
          result.frame_last = 1'b1;
          result.status     = ST_EMPTY;
        end else begin
          phase_next = PH_DATA;
        end
      end
    end

    // Buffer ended with the header still open
    if (!result_valid && item.chunk_end &&
        (phase_next == PH_HDR1 || phase_next == PH_EXT || phase_next == PH_KEY)) begin
      phase_next    = PH_HDR0;
      cnt_next      = 3'd0;
      result_valid  = 1'b1;
      result.status = ST_INCOMPLETE;
    end

    // no byte in the input register, nothing to report
    if (!item_valid) begin
      result_valid = 1'b0;
    end

    result.fin_bit      = fin_next;
    result.frame_opcode = opcode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HDR0;
      cnt       <= 3'd0;
      remaining <= '0;
      key       <= '0;
      pos       <= 2'd0;
      masked    <= 1'b0;
      fin       <= 1'b0;
      opcode    <= 4'd0;
    end else if (fire) begin
      phase     <= phase_next;
      cnt       <= cnt_next;
      remaining <= remaining_next;
      key       <= key_next;
      pos       <= pos_next;
      masked    <= masked_next;
      fin       <= fin_next;
      opcode    <= opcode_next;
    end
  end

  a_data_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> remaining != '0)
    else $error("payload phase with zero bytes remaining");

  a_data_gives_result: assert property (@(posedge clk) disable iff (rst)
    (item_valid && phase == PH_DATA) |-> result_valid && result.status == ST_DATA)
    else $error("payload byte without a payload result");

  a_incomplete_clean: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status == ST_INCOMPLETE) |->
      !result.frame_last && result.out_byte == 8'd0)
    else $error("incomplete-header result carries data");

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    (fire && result_valid && result.frame_last) |=> phase == PH_HDR0)
    else $error("frame end did not return to header parsing");

endmodule

`default_nettype wire

### hw/rtl/wsd_out_reg.sv
// Result register of the deframer: holds one result transfer and tells the
// upstream stages when they may advance. Depends on wsd_pkg.
`default_nettype none

module wsd_out_reg
  import wsd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      result_valid,
  input  wire out_item_t result,
  output logic           advance,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  assign advance = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= result_valid;
    end
    if (advance && result_valid) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/websocket_frame_deframer.sv
// WebSocket (RFC 6455 receive side) frame deframer, top level.
// Uses wsd_pkg, wsd_in_reg, wsd_parser, wsd_out_reg.
// Input channel (in_valid/in_ready/in_data): one received byte per transfer,
// with chunk_end set on the last byte of a receive buffer.
// Output channel (out_valid/out_ready/out_data): at most one result per
// input byte: an unmasked payload byte (status data), an empty-frame marker
// for a zero-length frame, or a header-incomplete report when a buffer
// ends inside a header. Header bytes otherwise give no result.
// Each result carries FIN and opcode of its frame; frame_last marks the
// final payload byte (or the empty-frame marker).
// Throughput: one byte per cycle, sustained while out_ready stays high. The parse
// state (phase, length counter, mask key and index) is updated once per byte
// between the input register and the result register, and each result is
// registered in the result register before it reaches out_data.
// Stall: when out_ready is low and a result is held, the input register
// also holds and in_ready drops once it is full; nothing is lost.
// Reset (rst, synchronous): both registers empty, parser waits for the first
// header byte with length, key and flags cleared.
// LENGTH_WIDTH (16..64) sets the payload length counter; longer extended
// lengths saturate to all ones.
`default_nettype none

module websocket_frame_deframer
  import wsd_pkg::*;
#(
  parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_data
);

  logic      advance;      // result register can take a new value
  logic      item_valid;
  in_item_t  item;
  logic      result_valid;
  out_item_t result;

  wsd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  wsd_parser #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .advance      (advance),
    .item         (item),
    .result_valid (result_valid),
    .result       (result)
  );

  wsd_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .result_valid (result_valid),
    .result       (result),
    .advance      (advance),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

endmodule

`default_nettype wire

### dv/tb_top.sv
// Self-checking testbench for websocket_frame_deframer: a byte-level parse
// predictor in a scoreboard class, random idling on both channels.
// Depends on hw/rtl/wsd_pkg.sv and the deframer RTL.
`default_nettype none

module tb_top
  import wsd_pkg::*;
;

  localparam int LW        = LENGTH_WIDTH_DEF;
  localparam int LIMIT     = 500000;  // cycles before the run is declared hung
  localparam int RAND_ITEMS = 650;
  localparam int HOLD_AT   = 120;     // results seen before the long out_ready hold-off
  localparam int HOLD_LEN  = 500;

  // Tracks the deframer parse state byte by byte and keeps the results that
  // the accepted bytes should produce, oldest first.
  class deframe_checker #(int LW = 64);
    typedef enum logic [2:0] {PH_HDR0, PH_HDR1, PH_EXT, PH_KEY, PH_DATA} phase_e;

    phase_e        phase     = PH_HDR0;
    logic [2:0]    hdr_left  = '0;   // header bytes left in this phase, minus one
    logic [LW-1:0] remaining = '0;
    logic [31:0]   key       = '0;
    logic [1:0]    key_idx   = '0;
    logic          masked    = 1'b0;
    logic          fin       = 1'b0;
    logic [3:0]    opcode    = '0;
    out_item_t     pending_results[$];
    int            errors    = 0;
    int            results   = 0;

    function out_item_t result_of(logic [7:0] b, logic last, status_t st);
      out_item_t r;
      r.out_byte     = b;
      r.frame_last   = last;
      r.fin_bit      = fin;
      r.frame_opcode = opcode;
      r.status       = st;
      return r;
    endfunction

    // Header complete: start the payload, or flag an empty frame.
    function bit close_header(output out_item_t r);
      key_idx  = '0;
      hdr_left = '0;
      r        = '0;
      if (remaining == '0) begin
        phase = PH_HDR0;
        r     = result_of(8'h00, 1'b1, ST_EMPTY);
        return 1'b1;
      end
      phase = PH_DATA;
      return 1'b0;
    endfunction

    function bit length_done(output out_item_t r);
      r = '0;
      if (masked) begin
        phase    = PH_KEY;
        hdr_left = 3'd3;
        return 1'b0;
      end
      return close_header(r);
    endfunction

    function void parse_byte(in_item_t it);
      logic [7:0] b;
      logic [7:0] kb;
      out_item_t  r;
      bit         have;
      b    = it.in_byte;
      have = 1'b0;
      r    = '0;
      case (phase)
        PH_HDR1: begin
          masked = b[7];
          if (b[6:0] <= LEN_MAX7) begin
            remaining      = '0;
            remaining[6:0] = b[6:0];
            have           = length_done(r);
          end else begin
            remaining = '0;
            phase     = PH_EXT;
            hdr_left  = (b[6:0] == LEN_EXT16) ? 3'd1 : 3'd7;
          end
        end
        PH_EXT: begin
          // lengths beyond the counter width stick at all ones
          if (remaining > ({LW{1'b1}} >> 8)) remaining = '1;
          else remaining = {remaining[LW-9:0], b};
          if (hdr_left == 3'd0) have = length_done(r);
          else hdr_left = hdr_left - 3'd1;
        end
        PH_KEY: begin
          key = {key[23:0], b};
          if (hdr_left == 3'd0) have = close_header(r);
          else hdr_left = hdr_left - 3'd1;
        end
        PH_DATA: begin
          // key index runs over the whole payload, first key byte on top
          kb        = masked ? key[8*(3-key_idx) +: 8] : 8'h00;
          key_idx   = key_idx + 2'd1;
          remaining = remaining - 1'b1;
          if (remaining == '0) phase = PH_HDR0;
          r    = result_of(b ^ kb, remaining == '0, ST_DATA);
          have = 1'b1;
        end
        default: begin
          fin       = b[7];
          opcode    = b[3:0];
          masked    = 1'b0;
          remaining = '0;
          key_idx   = '0;
          hdr_left  = '0;
          phase     = PH_HDR1;
        end
      endcase
      // buffer ended with the header unfinished
      if (!have && it.chunk_end &&
          (phase == PH_HDR1 || phase == PH_EXT || phase == PH_KEY)) begin
        phase    = PH_HDR0;
        hdr_left = '0;
        r        = result_of(8'h00, 1'b0, ST_INCOMPLETE);
        have     = 1'b1;
      end
      if (have) pending_results.push_back(r);
    endfunction

    function string describe(out_item_t x);
      return $sformatf("byte=%02h last=%b fin=%b op=%h st=%0d",
                       x.out_byte, x.frame_last, x.fin_bit, x.frame_opcode, x.status);
    endfunction

    function void complain(string what, string want_s, out_item_t got);
      errors++;
      if (errors <= 10)
        $display("%s at %0t: expected %s, got %s", what, $time, want_s, describe(got));
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      results++;
      if (pending_results.size() == 0) begin
        complain("unexpected result", "none", got);
        return;
      end
      want = pending_results[0];
      pending_results.delete(0);
      if (got.out_byte !== want.out_byte || got.frame_last !== want.frame_last ||
          got.fin_bit !== want.fin_bit || got.frame_opcode !== want.frame_opcode ||
          got.status !== want.status)
        complain("result mismatch", describe(want), got);
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  logic      hold_off  = 1'b0;   // long receiver hold-off, driven by its own process
  int        cycles    = 0;
  in_item_t  stim_q[$];

  deframe_checker #(LW) sb = new;

  websocket_frame_deframer #(.LENGTH_WIDTH(LW)) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #10 clk = ~clk;

  // Watchdog: a correct run finishes far below this.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Transfers are sampled at the edge, before any nonblocking update lands.
  // Inputs are noted first so a same-edge result would still find its entry.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.parse_byte(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  // Idle length: mostly none or short, now and then a long one.
  function automatic int idle_len();
    int roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void push(logic [7:0] b, logic ce);
    in_item_t it;
    it.in_byte   = b;
    it.chunk_end = ce;
    stim_q.push_back(it);
  endfunction

  // One frame with random header and content. A broken frame has its buffer
  // end somewhere before the last header byte, so the header never finishes.
  function automatic void add_frame(bit broken);
    logic [7:0]  hdr[$];
    int unsigned len;
    int          kind;
    int          cut;
    bit          mask_on;
    hdr.push_back(8'($urandom_range(0, 255)));
    mask_on = $urandom_range(0, 1);
    kind    = $urandom_range(0, 99);
    if (kind < 60) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 125) : $urandom_range(0, 12);
      hdr.push_back({mask_on, 7'(len)});
    end else if (kind < 85) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(126, 300) : $urandom_range(0, 20);
      hdr.push_back({mask_on, LEN_EXT16});
      hdr.push_back(8'(len >> 8));
      hdr.push_back(8'(len));
    end else begin
      len = $urandom_range(0, 20);
      hdr.push_back({mask_on, LEN_EXT64});
      repeat (6) hdr.push_back(8'h00);
      hdr.push_back(8'(len >> 8));
      hdr.push_back(8'(len));
    end
    if (mask_on) repeat (4) hdr.push_back(8'($urandom_range(0, 255)));
    if (broken) begin
      cut = $urandom_range(0, hdr.size() - 2);
      for (int i = 0; i <= cut; i++)
        push((i >= 2) ? 8'($urandom_range(0, 255)) : hdr[i], i == cut);
      return;
    end
    foreach (hdr[i])
      push(hdr[i], (i == hdr.size() - 1) && ($urandom_range(0, 4) == 0));
    repeat (len) push(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
  endfunction

  // Hold valid with a fixed payload until the transfer happens.
  task automatic send_byte(in_item_t it, bit calm);
    int gap;
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  // Receiver: random stalls, calm stretches with ready held high, and one
  // long hold-off so the input side backs up.
  initial begin
    int stall = 0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if ((cycles / 400) % 5 == 0 || $urandom_range(0, 3) != 0) begin
        out_ready <= 1'b1;
      end else begin
        stall = idle_len();
        out_ready <= 1'b0;
      end
    end
  end

  initial begin
    while (sb.results < HOLD_AT) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_LEN) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    bit calm = 1'b0;
    int target;

    // unmasked empty frame, FIN set, text opcode
    push(8'h81, 0); push(8'h00, 0);
    // masked empty frame; buffer ends on the last key byte, still one empty marker
    push(8'h0F, 0); push(8'h80, 0);
    push(8'hFF, 0); push(8'h00, 0); push(8'hA5, 0); push(8'h5A, 1);
    // RSV bits set, masked 3-byte payload: buffer ends right after the header
    // (no report) and again inside the payload (ignored)
    push(8'hF2, 0); push(8'h83, 0);
    push(8'hFF, 0); push(8'h00, 0); push(8'h0F, 0); push(8'hF0, 1);
    push(8'h00, 0); push(8'hFF, 1); push(8'h3C, 0);
    // buffer ends after the first header byte
    push(8'h88, 1);
    // buffer ends inside a 16-bit extended length
    push(8'h01, 0); push(8'hFE, 0); push(8'h00, 1);
    // 16-bit extended length of zero
    push(8'h00, 0); push(8'h7E, 0); push(8'h00, 0); push(8'h00, 0);

    // mostly well-formed frames, some cut short inside the header
    target = stim_q.size() + RAND_ITEMS;
    while (stim_q.size() < target) add_frame($urandom_range(0, 99) < 15);

    // 64-bit length with every bit set, reserved top bit included: this frame
    // never ends, so it closes the stream
    push(8'h8A, 0); push(8'hFF, 0);
    repeat (8) push(8'hFF, 0);
    repeat (4) push(8'($urandom_range(0, 255)), 0);
    repeat (6) push(8'($urandom_range(0, 255)), $urandom_range(0, 1));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_q[i]) begin
      if (i % 80 == 0) calm = ($urandom_range(0, 3) == 0);
      send_byte(stim_q[i], calm);
    end
    in_valid <= 1'b0;

    // let the monitor see the final transfer, then drain
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (sb.errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
